// ===== hdl/tknl_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tknl_pkg: shared types and constants for the top-k nearest list
// Widths, command codes, beat structs and the cell control struct.
// ----------------------------------------------------------------------------
package tknl_pkg;

  localparam int MAX_NEIGHBORS = 8;
  localparam int DIST_BITS     = 32;
  localparam int INDEX_BITS    = 16;
  localparam int CFG_BITS      = 4;
  // holds 0..MAX_NEIGHBORS
  localparam int KW            = $clog2(MAX_NEIGHBORS + 1);
  localparam int SLOT_BITS     = (MAX_NEIGHBORS > 1) ? $clog2(MAX_NEIGHBORS) : 1;

  localparam logic [DIST_BITS-1:0] DIST_EMPTY = {DIST_BITS{1'b1}};

  localparam logic [1:0] MODE_OFFER = 2'd0;
  localparam logic [1:0] MODE_CLEAR = 2'd1;
  localparam logic [1:0] MODE_DUMP  = 2'd2;

  typedef struct packed {
    logic [1:0]            mode;
    logic [DIST_BITS-1:0]  query_distance;
    logic [INDEX_BITS-1:0] query_row;
  } cmd_t;

  typedef struct packed {
    logic [DIST_BITS-1:0]  slot_distance;
    logic [INDEX_BITS-1:0] slot_index;
    logic                  slot_filled;
    logic                  last_slot;
  } result_t;

  typedef struct packed {
    logic offer;   // offer beat this cycle
    logic clear;   // clear beat this cycle
    logic in_use;  // slot lies below k
  } cell_ctrl_t;

endpackage

// ===== hdl/tknl_cell.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tknl_cell: one slot of the sorted list
// Holds a distance and index; on an offer it keeps, takes the candidate, or
// takes its left neighbor's entry (shift toward larger slots).
// ----------------------------------------------------------------------------
module tknl_cell (
  input  logic                             clk,
  input  logic                             rst,
  input  tknl_pkg::cell_ctrl_t             ctrl,
  input  logic [tknl_pkg::DIST_BITS-1:0]   cand_dist,
  input  logic [tknl_pkg::INDEX_BITS-1:0]  cand_idx,
  input  logic [tknl_pkg::DIST_BITS-1:0]   left_dist,
  input  logic [tknl_pkg::INDEX_BITS-1:0]  left_idx,
  input  logic                             left_gt,
  output logic [tknl_pkg::DIST_BITS-1:0]   slot_dist,
  output logic [tknl_pkg::INDEX_BITS-1:0]  idx,
  output logic                             gt
);
  import tknl_pkg::*;

  // list stays ascending, so gt across the row is a thermometer code
  assign gt = (slot_dist > cand_dist);

  always_ff @(posedge clk) begin
    if (rst || ctrl.clear) begin
      slot_dist <= DIST_EMPTY;
      idx       <= '0;
    end else if (ctrl.offer && ctrl.in_use && gt) begin
      if (left_gt) begin
        slot_dist <= left_dist;
        idx       <= left_idx;
      end else begin
        slot_dist <= cand_dist;
        idx       <= cand_idx;
      end
    end
  end

endmodule

// ===== hdl/top_k_nearest_list.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// top_k_nearest_list: top-k insertion sorter over a row of slot cells
// Keeps the k smallest distances offered, ascending, with their row indexes.
// ----------------------------------------------------------------------------
// Offer and clear beats leave busy low, so a distance engine can offer one
// candidate every clock while no dump is running. A dump beat raises busy
// while k slots are read (k = neighbors_in_use, 0 acting as 1 and anything
// above MAX_NEIGHBORS acting as MAX_NEIGHBORS); the dump sequencer steps
// through the slots and each is registered onto result with strobe high,
// one slot per cycle, last_slot marking slot k-1. The dump rate is set by
// the single read mux over the cell row. The receiver cannot stall: each
// result is valid for exactly one cycle. Empty slots read as all-ones
// distance, index 0, slot_filled low. Ties keep the earlier arrival ahead.
// Write cfg only while busy is low and no dump beats are still due.
// ----------------------------------------------------------------------------
module top_k_nearest_list (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  output logic                          busy,
  input  tknl_pkg::cmd_t                cmd,
  input  logic                          cfg_we,
  input  logic [tknl_pkg::CFG_BITS-1:0] cfg_data,
  output logic                          strobe,
  output tknl_pkg::result_t             result
);
  import tknl_pkg::*;

  logic [CFG_BITS-1:0]   k_reg;        // neighbors_in_use
  logic [KW-1:0]         k_eff;        // clamped k
  logic                  dumping;
  logic [SLOT_BITS-1:0]  cnt;          // slot being read out
  logic                  accept;
  logic                  is_last;

  logic [DIST_BITS-1:0]  cell_dist [MAX_NEIGHBORS];
  logic [INDEX_BITS-1:0] cell_idx  [MAX_NEIGHBORS];
  logic                  cell_gt   [MAX_NEIGHBORS];

  logic [DIST_BITS-1:0]  rd_dist;
  logic [INDEX_BITS-1:0] rd_idx;
  logic                  rd_filled;

  assign busy   = dumping;
  assign accept = start && !busy;

  // config register
  always_ff @(posedge clk) begin
    if (rst) begin
      k_reg <= CFG_BITS'(MAX_NEIGHBORS);
    end else if (cfg_we) begin
      k_reg <= cfg_data;
    end
  end

  // clamp k to 1..MAX_NEIGHBORS
  always_comb begin
    if (k_reg == '0) begin
      k_eff = KW'(1);
    end else if (int'(k_reg) > MAX_NEIGHBORS) begin
      k_eff = KW'(MAX_NEIGHBORS);
    end else begin
      k_eff = KW'(k_reg);
    end
  end

  // cell row: each slot looks at its left neighbor only
  for (genvar i = 0; i < MAX_NEIGHBORS; i++) begin : g_cell
    cell_ctrl_t ctrl;

    assign ctrl.offer  = accept && (cmd.mode == MODE_OFFER);
    assign ctrl.clear  = accept && (cmd.mode == MODE_CLEAR);
    assign ctrl.in_use = (k_eff > KW'(i));

    if (i == 0) begin : g_head
      tknl_cell u_cell (
        .clk       (clk),
        .rst       (rst),
        .ctrl      (ctrl),
        .cand_dist (cmd.query_distance),
        .cand_idx  (cmd.query_row),
        .left_dist (cmd.query_distance),
        .left_idx  (cmd.query_row),
        .left_gt   (1'b0),
        .slot_dist (cell_dist[i]),
        .idx       (cell_idx[i]),
        .gt        (cell_gt[i])
      );
    end else begin : g_body
      tknl_cell u_cell (
        .clk       (clk),
        .rst       (rst),
        .ctrl      (ctrl),
        .cand_dist (cmd.query_distance),
        .cand_idx  (cmd.query_row),
        .left_dist (cell_dist[i-1]),
        .left_idx  (cell_idx[i-1]),
        .left_gt   (cell_gt[i-1]),
        .slot_dist (cell_dist[i]),
        .idx       (cell_idx[i]),
        .gt        (cell_gt[i])
      );
    end
  end

  // dump read port
  assign rd_dist   = cell_dist[cnt];
  assign rd_filled = (rd_dist != DIST_EMPTY);
  assign rd_idx    = rd_filled ? cell_idx[cnt] : '0;
  assign is_last   = (KW'(cnt) == (k_eff - KW'(1)));

  // dump sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      dumping <= 1'b0;
      cnt     <= '0;
    end else if (dumping) begin
      cnt <= cnt + SLOT_BITS'(1);
      if (is_last) begin
        dumping <= 1'b0;
      end
    end else if (accept && (cmd.mode == MODE_DUMP)) begin
      dumping <= 1'b1;
      cnt     <= '0;
    end
  end

  // output register: one beat per dump cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      strobe <= 1'b0;
    end else begin
      strobe <= dumping;
    end
  end

  always_ff @(posedge clk) begin
    result.slot_distance <= rd_dist;
    result.slot_index    <= rd_idx;
    result.slot_filled   <= rd_filled;
    result.last_slot     <= is_last;
  end

  // ---- assertions ----
  a_strobe_after_busy: assert property (@(posedge clk) disable iff (rst)
    strobe |-> $past(busy))
    else $error("result beat without a dump cycle");

  a_busy_ends_on_last: assert property (@(posedge clk) disable iff (rst)
    ($fell(busy) && !$past(rst)) |-> (strobe && result.last_slot))
    else $error("dump ended without last slot");

  a_last_frees: assert property (@(posedge clk) disable iff (rst)
    (strobe && result.last_slot) |-> !busy)
    else $error("busy after last slot");

  a_empty_slot: assert property (@(posedge clk) disable iff (rst)
    (strobe && !result.slot_filled) |->
      (result.slot_index == '0 && result.slot_distance == DIST_EMPTY))
    else $error("empty slot carries data");

  a_sorted: assert property (@(posedge clk) disable iff (rst)
    (cell_dist[0] <= cell_dist[MAX_NEIGHBORS-1]))
    else $error("slot list out of order");

endmodule

// ===== dv/top_k_nearest_list_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// top_k_nearest_list_tb: self-checking bench for the top-k nearest list
// Drives offer, clear, dump and unused-mode beats with random gaps, keeps a
// shadow copy of the sorted slot list, and checks every dumped slot against
// it field by field. k is rewritten between phases, extremes included.
// ----------------------------------------------------------------------------
module top_k_nearest_list_tb;
  import tknl_pkg::*;

  localparam logic [1:0] MODE_UNUSED = 2'd3;
  localparam int CYCLE_LIMIT = 60000;
  // cycles allowed after the last slot before touching cfg or ending
  localparam int SETTLE_CYCLES = 6;

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                start = 1'b0;
  logic                busy;
  cmd_t                cmd = '0;
  logic                cfg_we = 1'b0;
  logic [CFG_BITS-1:0] cfg_data = '0;
  logic                strobe;
  result_t             result;

  top_k_nearest_list i_dut (
    .clk      (clk),
    .rst      (rst),
    .start    (start),
    .busy     (busy),
    .cmd      (cmd),
    .cfg_we   (cfg_we),
    .cfg_data (cfg_data),
    .strobe   (strobe),
    .result   (result)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  // --------------------------------------------------------------------------
  // Shadow list: distances ascending, with row indexes, plus the k register.
  // --------------------------------------------------------------------------
  logic [DIST_BITS-1:0]  near_dist [MAX_NEIGHBORS];
  logic [INDEX_BITS-1:0] near_idx  [MAX_NEIGHBORS];
  logic [CFG_BITS-1:0]   k_setting = CFG_BITS'(MAX_NEIGHBORS);
  result_t               expected_slots[$];
  int                    mismatches = 0;
  int                    cycle_count = 0;
  bit                    idle_enabled = 1'b1;

  initial begin
    for (int s = 0; s < MAX_NEIGHBORS; s++) begin
      near_dist[s] = DIST_EMPTY;
      near_idx[s]  = '0;
    end
  end

  // k as the block uses it: 0 acts as 1, above the slot count clamps down
  function automatic int active_slots();
    if (k_setting == 0) return 1;
    if (k_setting > MAX_NEIGHBORS) return MAX_NEIGHBORS;
    return int'(k_setting);
  endfunction

  // Insertion: drop unless strictly below slot k-1; larger entries move down,
  // equal ones stay ahead so the earlier arrival wins a tie.
  function automatic void insert_candidate(logic [DIST_BITS-1:0] distance,
                                           logic [INDEX_BITS-1:0] idx);
    int k;
    int pos;
    k   = active_slots();
    pos = k - 1;
    if (distance >= near_dist[k-1]) return;
    while (pos > 0 && near_dist[pos-1] > distance) begin
      near_dist[pos] = near_dist[pos-1];
      near_idx[pos]  = near_idx[pos-1];
      pos--;
    end
    near_dist[pos] = distance;
    near_idx[pos]  = idx;
  endfunction

  function automatic void predict_beat(cmd_t c);
    int      k;
    result_t slot;
    case (c.mode)
      MODE_OFFER: begin
        insert_candidate(c.query_distance, c.query_row);
      end
      MODE_CLEAR: begin
        // clear reaches every slot, including those beyond k
        for (int s = 0; s < MAX_NEIGHBORS; s++) begin
          near_dist[s] = DIST_EMPTY;
          near_idx[s]  = '0;
        end
      end
      MODE_DUMP: begin
        k = active_slots();
        for (int s = 0; s < k; s++) begin
          slot.slot_distance = near_dist[s];
          slot.slot_filled   = (near_dist[s] != DIST_EMPTY);
          slot.slot_index    = slot.slot_filled ? near_idx[s] : '0;
          slot.last_slot     = (s == k - 1);
          expected_slots.push_back(slot);
        end
      end
      default: ;  // unused mode: no effect
    endcase
  endfunction

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    $display("%0t: %s got %0h expected %0h", $time, what, got, want);
    mismatches++;
  endtask

  task automatic check_slot(input result_t got);
    result_t want;
    if (expected_slots.size() == 0) begin
      report_mismatch("unexpected slot beat, distance", 64'(got.slot_distance), '0);
    end else begin
      want = expected_slots.pop_front();
      if (got.slot_distance !== want.slot_distance)
        report_mismatch("slot_distance", 64'(got.slot_distance),
                        64'(want.slot_distance));
      if (got.slot_index !== want.slot_index)
        report_mismatch("slot_index", 64'(got.slot_index), 64'(want.slot_index));
      if (got.slot_filled !== want.slot_filled)
        report_mismatch("slot_filled", 64'(got.slot_filled), 64'(want.slot_filled));
      if (got.last_slot !== want.last_slot)
        report_mismatch("last_slot", 64'(got.last_slot), 64'(want.last_slot));
    end
  endtask

  // Monitor: all sampling at the rising edge sees pre-edge values. Result
  // check runs before the new beat is predicted; a dump's slots come later.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("end of test: mismatches");
      $finish;
    end
    if (!rst) begin
      if (strobe) check_slot(result);
      if (cfg_we) k_setting = cfg_data;
      if (start && !busy) predict_beat(cmd);
    end
  end

  // --------------------------------------------------------------------------
  // Drivers
  // --------------------------------------------------------------------------
  // Sends one beat and returns at the edge that accepted it, start still high;
  // the next call or a drain drives start again in that same step.
  task automatic send_beat(input logic [1:0] mode,
                           input logic [DIST_BITS-1:0] distance,
                           input logic [INDEX_BITS-1:0] idx);
    if (idle_enabled && $urandom_range(0, 99) < 8) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    start <= 1'b1;
    cmd   <= '{mode: mode, query_distance: distance, query_row: idx};
    do @(posedge clk); while (busy);
  endtask

  // Hold off until every dumped slot has come and the block is idle.
  task automatic wait_for_slots();
    start <= 1'b0;
    @(posedge clk);
    while (expected_slots.size() != 0 || busy) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_k(input logic [CFG_BITS-1:0] value);
    wait_for_slots();
    cfg_we   <= 1'b1;
    cfg_data <= value;
    @(posedge clk);
    cfg_we   <= 1'b0;
  endtask

  function automatic logic [DIST_BITS-1:0] pick_distance();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return DIST_EMPTY;
      2:       return DIST_EMPTY - 1;
      3, 4, 5: return DIST_BITS'($urandom_range(0, 15));  // dense: many ties
      default: return DIST_BITS'($urandom);
    endcase
  endfunction

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------
  task automatic test_dump_after_reset();
    send_beat(MODE_DUMP, '0, '0);
  endtask

  task automatic test_field_extremes();
    send_beat(MODE_OFFER, '0, 16'hFFFF);
    send_beat(MODE_OFFER, DIST_EMPTY, 16'h1234);  // empty never gets in
    send_beat(MODE_OFFER, DIST_EMPTY - 1, '0);
    send_beat(MODE_OFFER, 32'h8000_0000, 16'h8000);
    send_beat(MODE_DUMP, DIST_EMPTY, 16'hFFFF);
  endtask

  task automatic test_ties();
    send_beat(MODE_OFFER, 32'd7, 16'd1);
    send_beat(MODE_OFFER, 32'd7, 16'd2);
    send_beat(MODE_OFFER, 32'd3, 16'd3);
    send_beat(MODE_OFFER, 32'd7, 16'd4);
    send_beat(MODE_DUMP, '0, '0);
  endtask

  task automatic test_unused_mode();
    send_beat(MODE_UNUSED, '0, '0);
    send_beat(MODE_UNUSED, DIST_BITS'($urandom), INDEX_BITS'($urandom));
    send_beat(MODE_DUMP, '0, '0);
  endtask

  // list is nearly full here; a small k must leave the upper slots as they are
  task automatic test_slots_beyond_k();
    write_k(4'd3);
    send_beat(MODE_OFFER, 32'd1, 16'd5);
    send_beat(MODE_DUMP, '0, '0);
    write_k(4'd8);
    send_beat(MODE_DUMP, '0, '0);
  endtask

  task automatic test_k_limits();
    write_k(4'd0);  // acts as one slot
    send_beat(MODE_OFFER, 32'd9, 16'd9);
    send_beat(MODE_OFFER, 32'd4, 16'd4);
    send_beat(MODE_DUMP, '0, '0);
    write_k(4'd15);  // clamps to all slots
    send_beat(MODE_DUMP, '0, '0);
    send_beat(MODE_CLEAR, '0, '0);
    send_beat(MODE_DUMP, '0, '0);
  endtask

  // Phases of random beats, each under its own k. Offers dominate so the
  // list fills and shifts; dumps are frequent enough to see most states.
  task automatic test_random_phases();
    logic [CFG_BITS-1:0] k_plan [9] = '{4'd1, 4'd8, 4'd4, 4'd15, 4'd2,
                                        4'd0, 4'd7, 4'd9, 4'd8};
    int                  pick;
    for (int p = 0; p < 9; p++) begin
      write_k(k_plan[p]);
      idle_enabled = (p != 2);  // one phase runs back to back
      for (int n = 0; n < 21; n++) begin
        // mid-phase hold-off until the list has been fully read out
        if (p == 4 && n == 12) wait_for_slots();
        pick = $urandom_range(0, 99);
        if (pick < 72)
          send_beat(MODE_OFFER, pick_distance(), INDEX_BITS'($urandom));
        else if (pick < 87)
          send_beat(MODE_DUMP, DIST_BITS'($urandom), INDEX_BITS'($urandom));
        else if (pick < 94)
          send_beat(MODE_CLEAR, DIST_BITS'($urandom), INDEX_BITS'($urandom));
        else
          send_beat(MODE_UNUSED, DIST_BITS'($urandom), INDEX_BITS'($urandom));
      end
      send_beat(MODE_DUMP, '0, '0);
    end
    idle_enabled = 1'b1;
  endtask

  initial begin
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    test_dump_after_reset();
    test_field_extremes();
    test_ties();
    test_unused_mode();
    test_slots_beyond_k();
    test_k_limits();
    test_random_phases();
    wait_for_slots();
    if (expected_slots.size() != 0)
      report_mismatch("slots never seen", 64'(expected_slots.size()), '0);
    if (mismatches == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
